>>> hw/rtl/sparse_term_accumulate_table_assert.svh
// Assertion macros for the term table; clock and reset are clk_i and rst_ni.
`ifndef SPARSE_TERM_ACCUMULATE_TABLE_ASSERT_SVH
`define SPARSE_TERM_ACCUMULATE_TABLE_ASSERT_SVH

// same-cycle implication
`define SPACC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPACC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/spacc_pkg.sv
package spacc_pkg;

  // default geometry
  localparam int MatrixDimDef      = 16;
  localparam int TermsPerBucketDef = 16;

  // key count after reset
  localparam logic [1:0] KeyFieldsReset = 2'd2;

  // stored term: keys over coefficient
  localparam int KeyW   = 32;
  localparam int CoefW  = 64;
  localparam int TermW  = KeyW + CoefW;

  // result status codes
  localparam logic [1:0] StatusAcc  = 2'd0;
  localparam logic [1:0] StatusIns  = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;

  typedef struct packed {
    logic [3:0]  row_index;
    logic [3:0]  col_index;
    logic [15:0] key_a;
    logic [15:0] key_b;
    logic [63:0] coefficient;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [63:0] coefficient_now;
    logic [4:0]  term_count;
  } out_word_t;

endpackage

>>> hw/rtl/sparse_term_accumulate_table.sv
// Lookup: an accepted word has its bucket count read, then the bucket's stored terms read and
//   compared one by one until a key matches or all are examined; an out-of-matrix bucket skips both.
// Flow: one word at a time; the next is taken once the result has moved to the output register,
//   which a stall on the output can hold up.
// Reset: a clearing pass writes every bucket count to zero, during which no input word is
//   taken. Term storage is not cleared.
module sparse_term_accumulate_table #(
  parameter int MATRIX_DIM       = spacc_pkg::MatrixDimDef,
  parameter int TERMS_PER_BUCKET = spacc_pkg::TermsPerBucketDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input words
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  spacc_pkg::in_word_t   in_word_i,
  // result words
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output spacc_pkg::out_word_t  out_word_o,
  // key count register
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_data_i
);

  localparam int Buckets = MATRIX_DIM * MATRIX_DIM;
  localparam int Slots   = Buckets * TERMS_PER_BUCKET;
  localparam int BktW    = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int TaddrW  = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int CntW    = $clog2(TERMS_PER_BUCKET + 1);
  localparam int KeyW    = spacc_pkg::KeyW;
  localparam int CoefW   = spacc_pkg::CoefW;
  localparam int TermW   = spacc_pkg::TermW;

  // sequencer states
  localparam logic [2:0] SClr  = 3'd0;
  localparam logic [2:0] SIdle = 3'd1;
  localparam logic [2:0] SCnt  = 3'd2;
  localparam logic [2:0] SCntd = 3'd3;
  localparam logic [2:0] SSrch = 3'd4;
  localparam logic [2:0] SDone = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [BktW-1:0]       clr_idx_q, clr_idx_d;
  logic [1:0]            kfu_q, kfu_d;
  logic                  pend_q, pend_d;
  logic                  out_valid_q, out_valid_d;

  logic [BktW-1:0]       bucket_q, bucket_d;
  logic [TaddrW-1:0]     base_q, base_d;
  logic                  oor_q, oor_d;
  logic [KeyW-1:0]       key_q, key_d;
  logic [CoefW-1:0]      coef_q, coef_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [CntW-1:0]       rd_idx_q, rd_idx_d;
  logic [CntW-1:0]       cmp_idx_q, cmp_idx_d;
  spacc_pkg::out_word_t  res_q, res_d;
  spacc_pkg::out_word_t  out_q, out_d;

  // RAM ports
  logic                  cnt_we, cnt_re;
  logic [BktW-1:0]       cnt_waddr;
  logic [CntW-1:0]       cnt_wdata, cnt_rdata;
  logic                  term_we, term_re;
  logic [TaddrW-1:0]     term_waddr, term_raddr;
  logic [TermW-1:0]      term_wdata, term_rdata;

  // compare and accumulate unit
  logic [KeyW-1:0]       key_mask;
  logic [KeyW-1:0]       rd_key;
  logic [CoefW-1:0]      sum;
  logic                  hit;
  logic                  issue;
  logic                  row_ok, col_ok;
  logic [31:0]           bucket_full;

  assign key_mask = kfu_q[1] ? 32'hFFFF_FFFF : 32'h0000_FFFF;
  assign rd_key   = term_rdata[TermW-1:CoefW];
  assign sum      = term_rdata[CoefW-1:0] + coef_q;
  assign hit      = pend_q && ((rd_key & key_mask) == key_q);
  assign issue    = rd_idx_q < cnt_q;

  // bucket decode of the incoming word
  assign row_ok      = 32'(in_word_i.row_index) < 32'(MATRIX_DIM);
  assign col_ok      = 32'(in_word_i.col_index) < 32'(MATRIX_DIM);
  assign bucket_full = 32'(in_word_i.row_index) * 32'(MATRIX_DIM)
                     + 32'(in_word_i.col_index);

  // per-bucket term counts
  spacc_ram #(
    .Width (CntW),
    .Depth (Buckets)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (bucket_q),
    .rdata_o (cnt_rdata)
  );

  // stored terms: keys and coefficient
  spacc_ram #(
    .Width (TermW),
    .Depth (Slots)
  ) u_term_ram (
    .clk_i   (clk_i),
    .we_i    (term_we),
    .waddr_i (term_waddr),
    .wdata_i (term_wdata),
    .re_i    (term_re),
    .raddr_i (term_raddr),
    .rdata_o (term_rdata)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    kfu_d       = kfu_q;
    pend_d      = pend_q;
    bucket_d    = bucket_q;
    base_d      = base_q;
    oor_d       = oor_q;
    key_d       = key_q;
    coef_d      = coef_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    cmp_idx_d   = cmp_idx_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    cnt_we      = 1'b0;
    cnt_re      = 1'b0;
    cnt_waddr   = bucket_q;
    cnt_wdata   = CntW'(cnt_q + 1'b1);
    term_we     = 1'b0;
    term_re     = 1'b0;
    term_raddr  = base_q + TaddrW'(rd_idx_q);
    term_waddr  = base_q + TaddrW'(cnt_q);
    term_wdata  = {key_q, coef_q};

    if (cfg_valid_i) begin
      kfu_d = cfg_data_i;
    end

    case (state_q)
      SClr: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_idx_q;
        cnt_wdata = '0;
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == BktW'(Buckets - 1)) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (in_valid_i) begin
          oor_d    = !(row_ok && col_ok);
          bucket_d = BktW'(bucket_full);
          base_d   = TaddrW'(bucket_full * 32'(TERMS_PER_BUCKET));
          key_d    = {in_word_i.key_b, in_word_i.key_a} & key_mask;
          coef_d   = in_word_i.coefficient;
          state_d  = SCnt;
        end
      end
      SCnt: begin
        if (oor_q) begin
          res_d   = '{status: spacc_pkg::StatusFull, slot: '0,
                      coefficient_now: '0, term_count: '0};
          state_d = SDone;
        end else begin
          cnt_re  = 1'b1;
          state_d = SCntd;
        end
      end
      SCntd: begin
        cnt_d    = cnt_rdata;
        rd_idx_d = '0;
        pend_d   = 1'b0;
        state_d  = SSrch;
      end
      SSrch: begin
        // read one term a cycle, compare the one read the cycle before
        term_re   = issue;
        pend_d    = issue;
        cmp_idx_d = rd_idx_q;
        if (issue) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        if (hit) begin
          term_we    = 1'b1;
          term_waddr = base_q + TaddrW'(cmp_idx_q);
          term_wdata = {rd_key, sum};
          res_d      = '{status: spacc_pkg::StatusAcc, slot: 4'(32'(cmp_idx_q)),
                         coefficient_now: sum, term_count: 5'(32'(cnt_q))};
          pend_d     = 1'b0;
          state_d    = SDone;
        end else if (!issue) begin
          if (cnt_q == CntW'(TERMS_PER_BUCKET)) begin
            res_d = '{status: spacc_pkg::StatusFull, slot: '0,
                      coefficient_now: '0, term_count: 5'(32'(cnt_q))};
          end else begin
            term_we = 1'b1;
            cnt_we  = 1'b1;
            res_d   = '{status: spacc_pkg::StatusIns, slot: 4'(32'(cnt_q)),
                        coefficient_now: coef_q,
                        term_count: 5'(32'(cnt_q) + 32'd1)};
          end
          state_d = SDone;
        end
      end
      SDone: begin
        // hand over once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClr;
      clr_idx_q   <= '0;
      kfu_q       <= spacc_pkg::KeyFieldsReset;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      kfu_q       <= kfu_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    bucket_q  <= bucket_d;
    base_q    <= base_d;
    oor_q     <= oor_d;
    key_q     <= key_d;
    coef_q    <= coef_d;
    cnt_q     <= cnt_d;
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign cfg_ready_o = 1'b1;

  `include "sparse_term_accumulate_table_assert.svh"

  `SPACC_ASSERT_NEXT(a_accept_starts, in_valid_i && !in_stall_o, state_q == SCnt,
                     "accepted word did not start a lookup")
  `SPACC_ASSERT_NOW(a_search_bounds, state_q == SSrch,
                    (rd_idx_q <= cnt_q) && (32'(cnt_q) <= 32'(TERMS_PER_BUCKET)),
                    "search index beyond bucket count")
  `SPACC_ASSERT_NOW(a_full_zero, out_valid_o && (out_word_o.status == spacc_pkg::StatusFull),
                    (out_word_o.slot == 4'd0) && (out_word_o.coefficient_now == '0),
                    "full result carries slot or coefficient")
  `SPACC_ASSERT_NOW(a_clear_stalls, state_q == SClr, in_stall_o && !out_valid_o,
                    "word traffic during clearing pass")

endmodule

>>> hw/rtl/spacc_ram.sv
// Simple dual port RAM: one write port, one read port, registered read data.
module spacc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
